// File: src/wcmd_pkg.sv
// shared constants, types and register codes of the 3x3 window convolver
package wcmd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int PIXEL_BITS  = 8;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int DIM_BITS    = 11;
  localparam int CFG_BITS    = 24;
  localparam int IDX_BITS    = 3;
  localparam int COEFF_BITS  = 8;
  localparam int SUM_BITS    = 20;
  localparam int PROD_BITS   = PIXEL_BITS + COEFF_BITS + 1;
  localparam int RSUM_BITS   = PROD_BITS + 2;
  localparam int TOTAL_BITS  = RSUM_BITS + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(5);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(5);
  localparam logic [CFG_BITS-1:0] COEFF_TOP_RESET    = 24'h000100;
  localparam logic [CFG_BITS-1:0] COEFF_MID_RESET    = 24'h010101;
  localparam logic [CFG_BITS-1:0] COEFF_BOTTOM_RESET = 24'h000100;
  localparam logic [SUM_BITS-1:0] TARGET_RESET = SUM_BITS'(5);

  typedef enum logic [IDX_BITS-1:0] {
    RegImageWidth   = 3'd0,
    RegImageHeight  = 3'd1,
    RegCoeffTop     = 3'd2,
    RegCoeffMid     = 3'd3,
    RegCoeffBottom  = 3'd4,
    RegMatchTarget  = 3'd5
  } cfg_reg_e;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] image_width;
    logic [DIM_BITS-1:0] image_height;
    logic [CFG_BITS-1:0] coeff_top;
    logic [CFG_BITS-1:0] coeff_mid;
    logic [CFG_BITS-1:0] coeff_bottom;
    logic [SUM_BITS-1:0] match_target;
  } cfg_t;

  typedef struct packed {
    pixel_t [2:0][2:0] px;
    logic              last;
  } win_word_t;

  typedef struct packed {
    logic empty;
    logic nearly_full;
  } q_status_t;

endpackage

// File: src/window_convolve_match_detect.sv
// top level: configuration registers, front end, queue and back end
// path to out_valid_o: front stage two, queue, products, row sums, output register
// throughput: one pixel per cycle while in_stall_o is low, set by the single line
// store port pair and the three-stage multiply and add pipeline in the back end
// reset: position, window and queue clear at once; line stores are not cleared,
// no initialisation pass, pixels are taken from the first cycle after reset
module window_convolve_match_detect import wcmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pixel_t              pixel_i,
  input  logic                frame_start_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SUM_BITS-1:0] window_sum_o,
  output logic                match_o,
  output logic                last_o
);

  cfg_t      cfg_q;
  logic      push, pop;
  win_word_t push_word, head_word;
  q_status_t q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= WIDTH_RESET;
      cfg_q.image_height <= HEIGHT_RESET;
      cfg_q.coeff_top    <= COEFF_TOP_RESET;
      cfg_q.coeff_mid    <= COEFF_MID_RESET;
      cfg_q.coeff_bottom <= COEFF_BOTTOM_RESET;
      cfg_q.match_target <= TARGET_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegImageWidth:  cfg_q.image_width  <= cfg_data_i[DIM_BITS-1:0];
        RegImageHeight: cfg_q.image_height <= cfg_data_i[DIM_BITS-1:0];
        RegCoeffTop:    cfg_q.coeff_top    <= cfg_data_i;
        RegCoeffMid:    cfg_q.coeff_mid    <= cfg_data_i;
        RegCoeffBottom: cfg_q.coeff_bottom <= cfg_data_i;
        RegMatchTarget: cfg_q.match_target <= cfg_data_i[SUM_BITS-1:0];
        default:        cfg_q <= cfg_q;
      endcase
    end
  end

  wcmd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_word_o   (push_word)
  );

  wcmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .head_word_o (head_word),
    .status_o    (q_status)
  );

  wcmd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_word_i  (head_word),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_sum_o (window_sum_o),
    .match_o      (match_o),
    .last_o       (last_o)
  );

endmodule

// File: src/wcmd_front.sv
// front end: raster position, line stores and 3x3 window, classifies each pixel
module wcmd_front import wcmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pixel_t    pixel_i,
  input  logic      frame_start_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output win_word_t push_word_o
);

  logic [COL_BITS-1:0] col_q, col_d, col_start, col_eff, wlast;
  logic [ROW_BITS-1:0] row_q, row_d, row_start, row_eff, hlast;
  logic                accept, produce, is_last;

  logic                vb_q;
  logic [COL_BITS-1:0] col_b_q;
  pixel_t              px_b_q;
  logic                prod_b_q, last_b_q;
  logic [2*PIXEL_BITS-1:0] rd_q;
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

  pixel_t [2:0][2:0] window_q, window_d;

  assign in_stall_o = q_status_i.nearly_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (cfg_i.image_width < DIM_BITS'(3)) begin
      wlast = COL_BITS'(2);
    end else if (32'(cfg_i.image_width) > MAX_WIDTH) begin
      wlast = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      wlast = COL_BITS'(cfg_i.image_width - DIM_BITS'(1));
    end
    if (cfg_i.image_height < DIM_BITS'(3)) begin
      hlast = ROW_BITS'(2);
    end else if (32'(cfg_i.image_height) > MAX_HEIGHT) begin
      hlast = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      hlast = ROW_BITS'(cfg_i.image_height - DIM_BITS'(1));
    end
  end

  always_comb begin
    col_start = frame_start_i ? '0 : col_q;
    row_start = frame_start_i ? '0 : row_q;
    col_eff   = (col_start > wlast) ? '0 : col_start;
    row_eff   = (row_start > hlast) ? '0 : row_start;
    produce   = (row_eff >= ROW_BITS'(2)) && (col_eff >= COL_BITS'(2));
    is_last   = (row_eff == hlast) && (col_eff == wlast);
    if (col_eff == wlast) begin
      col_d = '0;
      row_d = (row_eff == hlast) ? '0 : row_eff + ROW_BITS'(1);
    end else begin
      col_d = col_eff + COL_BITS'(1);
      row_d = row_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      vb_q  <= 1'b0;
    end else begin
      vb_q <= accept;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_b_q  <= col_eff;
      px_b_q   <= pixel_i;
      prod_b_q <= produce;
      last_b_q <= is_last;
    end
  end

  // upper row in the high half, middle row in the low half
  always_ff @(posedge clk_i) begin
    if (accept) begin
      // same column twice in a row: take the word still being written
      if (vb_q && (col_b_q == col_eff)) begin
        rd_q <= {rd_q[PIXEL_BITS-1:0], px_b_q};
      end else begin
        rd_q <= line_mem[col_eff];
      end
    end
    if (vb_q) begin
      line_mem[col_b_q] <= {rd_q[PIXEL_BITS-1:0], px_b_q};
    end
  end

  always_comb begin
    window_d = window_q;
    for (int r = 0; r < 3; r++) begin
      window_d[r][0] = window_q[r][1];
      window_d[r][1] = window_q[r][2];
    end
    window_d[0][2] = rd_q[2*PIXEL_BITS-1:PIXEL_BITS];
    window_d[1][2] = rd_q[PIXEL_BITS-1:0];
    window_d[2][2] = px_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (vb_q) begin
      window_q <= window_d;
    end
  end

  assign push_o           = vb_q && prod_b_q;
  assign push_word_o.px   = window_d;
  assign push_word_o.last = last_b_q;

endmodule

// File: src/wcmd_fifo.sv
// short queue of window words between front and back end
module wcmd_fifo import wcmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  win_word_t push_word_i,
  input  logic      pop_i,
  output win_word_t head_word_o,
  output q_status_t status_o
);

  win_word_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_BITS:0]   count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QPTR_BITS+1)'(1);
        2'b01:   count_q <= count_q - (QPTR_BITS+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  // two slots kept back: front end's second-stage word and the word being accepted
  assign head_word_o          = mem_q[rd_ptr_q];
  assign status_o.empty       = (count_q == '0);
  assign status_o.nearly_full = (count_q >= (QPTR_BITS+1)'(QUEUE_DEPTH - 2));

endmodule

// File: src/wcmd_back.sv
// back end: products, row sums, total and match flag, output register
module wcmd_back import wcmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  win_word_t           head_word_i,
  input  q_status_t           q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SUM_BITS-1:0] window_sum_o,
  output logic                match_o,
  output logic                last_o
);

  logic                        adv;
  logic                        vp_q, vr_q, out_valid_q;
  logic                        last_p_q, last_r_q;
  logic signed [PROD_BITS-1:0] prod_q [3][3];
  logic signed [RSUM_BITS-1:0] rsum_q [3];
  logic signed [TOTAL_BITS-1:0] total;
  logic [CFG_BITS-1:0]         coeff_rows [3];
  logic [SUM_BITS-1:0]         sum_q;
  logic                        match_q, last_q;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !q_status_i.empty;

  assign coeff_rows[0] = cfg_i.coeff_top;
  assign coeff_rows[1] = cfg_i.coeff_mid;
  assign coeff_rows[2] = cfg_i.coeff_bottom;

  assign total = TOTAL_BITS'(rsum_q[0]) + TOTAL_BITS'(rsum_q[1]) + TOTAL_BITS'(rsum_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q        <= 1'b0;
      vr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vp_q        <= pop_o;
      vr_q        <= vp_q;
      out_valid_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed({1'b0, head_word_i.px[r][c]})
                        * $signed(coeff_rows[r][COEFF_BITS*c +: COEFF_BITS]);
        end
        rsum_q[r] <= RSUM_BITS'(prod_q[r][0]) + RSUM_BITS'(prod_q[r][1])
                   + RSUM_BITS'(prod_q[r][2]);
      end
      last_p_q <= head_word_i.last;
      last_r_q <= last_p_q;
      sum_q    <= total[SUM_BITS-1:0];
      match_q  <= (total[SUM_BITS-1:0] == cfg_i.match_target);
      last_q   <= last_r_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_sum_o = sum_q;
  assign match_o      = match_q;
  assign last_o       = last_q;

endmodule

// File: src/wcmd_checker.sv
// port-level checks of the window convolver and their bind to the top level
module wcmd_checker import wcmd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pixel_t              pixel_i,
  input logic                frame_start_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [SUM_BITS-1:0] window_sum_o,
  input logic                match_o,
  input logic                last_o
);

  logic        in_acc, out_acc;
  logic [31:0] credit_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // words taken in less results taken out; words that give no result stay counted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_q + 32'(in_acc) - 32'(out_acc);
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(pixel_i)
      && $stable(frame_start_i))
    else $error("stalled input word changed or dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_sum_o)
      && $stable(match_o) && $stable(last_o))
    else $error("stalled result word changed or dropped");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> credit_q != 32'd0)
    else $error("result word without an accepted pixel");

  a_stall_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> credit_q != 32'd0)
    else $error("input stalled with nothing in flight");

  a_quiet_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result word right after reset");

endmodule

bind window_convolve_match_detect wcmd_checker u_checker (.*);
